// ----- design/wbr_pkg.sv -----
package wbr_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned TABLE_SIZE_DEF       = 2048;
  localparam int unsigned MAX_TABLE_FRAMES_DEF = 64;

  // Fixed field widths
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned CMD_W       = 1;
  localparam int unsigned WFRAME_W    = 6;
  localparam int unsigned WINDEX_W    = 11;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned POS_W       = 17;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned FRAC_W      = 16;

  // Position 1.0 in Q1.16
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1 << FRAC_W);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ  = 1'b1;

  // Blend arithmetic widths: (b - a) times unsigned Q0.16 fraction
  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W = DIFF_W + FRAC_W + 1;
  localparam int unsigned SUM_W  = PROD_W - FRAC_W;

  // Result queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = 2;
  localparam int unsigned OQ_CW    = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  // Tag that travels alongside one table read
  typedef struct packed {
    logic              vld;
    logic [1:0]        k;      // bit 1: second frame, bit 0: second neighbor
    logic [FRAC_W-1:0] sfrac;
    logic [FRAC_W-1:0] ffrac;
  } wbr_tag_t;

  // (b - a) * t, exact
  function automatic prod_t blend_prod(input sample_t a, input sample_t b,
                                       input logic [FRAC_W-1:0] t);
    logic signed [DIFF_W-1:0] d;
    logic signed [FRAC_W:0]   ts;
    begin
      d  = DIFF_W'(b) - DIFF_W'(a);
      ts = $signed({1'b0, t});
      return PROD_W'(d) * PROD_W'(ts);
    end
  endfunction

  // a + floor(prod / 65536); the upper bits of a signed product are the floor
  function automatic sample_t blend_sum(input sample_t a, input prod_t p);
    logic signed [SUM_W-1:0] q;
    logic signed [SUM_W-1:0] s;
    begin
      q = p[PROD_W-1:FRAC_W];
      s = SUM_W'(a) + q;
      return s[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

// ----- design/wbr_in_if.sv -----
interface wbr_in_if;
  import wbr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [WFRAME_W-1:0]    write_frame;
  logic [WINDEX_W-1:0]    write_index;
  logic signed [SAMPLE_BITS-1:0] write_sample;
  logic [PHASE_W-1:0]     read_phase;
  logic [POS_W-1:0]       read_position;

  modport source (output valid, command, write_frame, write_index, write_sample,
                  read_phase, read_position, input ready);
  modport sink (input valid, command, write_frame, write_index, write_sample,
                read_phase, read_position, output ready);
endinterface

// ----- design/wbr_out_if.sv -----
interface wbr_out_if;
  import wbr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

// ----- design/wbr_ram.sv -----
module wbr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- design/wbr_seq.sv -----
module wbr_seq #(
  parameter int unsigned TABLE_SIZE       = wbr_pkg::TABLE_SIZE_DEF,
  parameter int unsigned MAX_TABLE_FRAMES = wbr_pkg::MAX_TABLE_FRAMES_DEF,
  parameter int unsigned RAM_AW           = 17
) (
  input  logic                        clk,
  input  logic                        rst_n,
  wbr_in_if.sink                      in_ch,
  input  logic                        cfg_wr_en,
  input  logic [wbr_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        room,
  output logic                        rsv,
  output logic                        ram_en,
  output logic                        ram_we,
  output logic [RAM_AW-1:0]           ram_addr,
  output logic [wbr_pkg::SAMPLE_BITS-1:0] ram_wdata,
  output wbr_pkg::wbr_tag_t           tag_r
);
  import wbr_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam int unsigned FR_W  = (MAX_TABLE_FRAMES > 1) ? $clog2(MAX_TABLE_FRAMES) : 1;
  localparam int unsigned E_W   = FRAC_W + FR_W;
  localparam int unsigned P_W   = PHASE_W + IDX_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

  // Clamped frames_in_use minus one
  logic [FR_W-1:0] nfm1_r, nfm1_nxt;
  logic [31:0]     cfg_v, cfg_nf;

  always_comb begin
    cfg_v = 32'(cfg_wr_data);
    if (cfg_v == 32'd0) begin
      cfg_nf = 32'd1;
    end else if (cfg_v > 32'(MAX_TABLE_FRAMES)) begin
      cfg_nf = 32'(MAX_TABLE_FRAMES);
    end else begin
      cfg_nf = cfg_v;
    end
    nfm1_nxt = cfg_wr_en ? FR_W'(cfg_nf - 32'd1) : nfm1_r;
  end

  // Held item
  logic                   item_vld_r, item_vld_nxt;
  logic [CMD_W-1:0]       item_cmd_r;
  logic                   item_wok_r;
  logic [RAM_AW-1:0]      item_waddr_r;
  logic [SAMPLE_BITS-1:0] item_wdata_r;
  logic [IDX_W-1:0]       item_i1_r;
  logic [FRAC_W-1:0]      item_sfrac_r;
  logic [E_W-1:0]         item_e_r;
  logic [1:0]             cnt_r, cnt_nxt;

  logic             accept, item_last;
  logic [POS_W-1:0] pos_c;
  logic [E_W:0]     e_full;
  logic [P_W-1:0]   p_full;
  logic [31:0]      wf32, wi32;
  logic             wok;

  // Decode of the incoming item: phase and morph products
  always_comb begin
    pos_c  = (in_ch.read_position > POS_ONE) ? POS_ONE : in_ch.read_position;
    e_full = (E_W+1)'(pos_c) * (E_W+1)'(nfm1_r);
    p_full = P_W'(in_ch.read_phase) * P_W'(TABLE_SIZE);
    wf32   = 32'(in_ch.write_frame);
    wi32   = 32'(in_ch.write_index);
    wok    = (wf32 < 32'(MAX_TABLE_FRAMES)) && (wi32 < 32'(TABLE_SIZE));
  end

  assign item_last   = (item_cmd_r == CMD_WRITE) || (cnt_r == 2'd3);
  assign in_ch.ready = room && (!item_vld_r || item_last);
  assign accept      = in_ch.valid && in_ch.ready;
  assign rsv         = accept && (in_ch.command == CMD_READ);

  always_comb begin
    item_vld_nxt = item_vld_r;
    cnt_nxt      = cnt_r;
    if (item_vld_r && (item_cmd_r == CMD_READ)) begin
      cnt_nxt = cnt_r + 2'd1;
    end
    if (accept) begin
      item_vld_nxt = 1'b1;
      cnt_nxt      = 2'd0;
    end else if (item_vld_r && item_last) begin
      item_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      cnt_r      <= 2'd0;
      nfm1_r     <= '0;
      tag_r.vld  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      cnt_r      <= cnt_nxt;
      nfm1_r     <= nfm1_nxt;
      tag_r.vld  <= item_vld_r && (item_cmd_r == CMD_READ);
    end
    tag_r.k     <= cnt_r;
    tag_r.sfrac <= item_sfrac_r;
    tag_r.ffrac <= item_e_r[FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd_r   <= in_ch.command;
      item_wok_r   <= wok;
      item_waddr_r <= RAM_AW'({wf32[FR_W-1:0], wi32[IDX_W-1:0]});
      item_wdata_r <= in_ch.write_sample;
      item_i1_r    <= p_full[PHASE_W +: IDX_W];
      item_sfrac_r <= p_full[PHASE_W-1 -: FRAC_W];
      item_e_r     <= e_full[E_W-1:0];
    end
  end

  // Read address: four neighbors, frame pair on bit 1, sample pair on bit 0
  logic [FR_W-1:0]  f1, f2, fsel;
  logic [IDX_W-1:0] i2, isel;

  always_comb begin
    f1   = item_e_r[FRAC_W +: FR_W];
    f2   = (f1 == nfm1_r) ? f1 : f1 + FR_W'(1);
    i2   = (item_i1_r == IDX_LAST) ? '0 : item_i1_r + IDX_W'(1);
    fsel = cnt_r[1] ? f2 : f1;
    isel = cnt_r[0] ? i2 : item_i1_r;
  end

  // Port is used in issue order, so a read after a write sees the new value
  assign ram_we    = item_vld_r && (item_cmd_r == CMD_WRITE) && item_wok_r;
  assign ram_en    = ram_we || (item_vld_r && (item_cmd_r == CMD_READ));
  assign ram_addr  = ram_we ? item_waddr_r : RAM_AW'({fsel, isel});
  assign ram_wdata = item_wdata_r;

  a_no_accept_mid_read: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r && (item_cmd_r == CMD_READ) && (cnt_r != 2'd3) |=> item_vld_r)
    else $error("read item dropped before its four reads were issued");

  a_tag_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    ram_en && !ram_we |=> tag_r.vld && (tag_r.k == $past(cnt_r)))
    else $error("read tag out of step with table access");

  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> !tag_r.vld)
    else $error("write produced a read tag");

endmodule

// ----- design/wbr_interp.sv -----
module wbr_interp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wbr_pkg::wbr_tag_t               tag,
  input  logic [wbr_pkg::SAMPLE_BITS-1:0] rdata,
  output logic                            res_vld,
  output logic [wbr_pkg::SAMPLE_BITS-1:0] res_data
);
  import wbr_pkg::*;

  sample_t d;
  assign d = $signed(rdata);

  // Sample-pair stage: first neighbor held, product on the second
  sample_t           a_r;
  prod_t             pm_r;
  sample_t           pa_r;
  logic              pm_vld_r, pm_second_r;
  logic [FRAC_W-1:0] pm_ffrac_r;

  // Pair sum stage
  sample_t           s_r;
  logic              s_vld_r, s_second_r;
  logic [FRAC_W-1:0] s_ffrac_r;

  // Frame-pair stage
  sample_t s1_r;
  prod_t   fm_r;
  sample_t fa_r;
  logic    fm_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_vld_r <= 1'b0;
      s_vld_r  <= 1'b0;
      fm_vld_r <= 1'b0;
    end else begin
      pm_vld_r <= tag.vld && tag.k[0];
      s_vld_r  <= pm_vld_r;
      fm_vld_r <= s_vld_r && s_second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tag.vld && !tag.k[0]) begin
      a_r <= d;
    end
    pm_r        <= blend_prod(a_r, d, tag.sfrac);
    pa_r        <= a_r;
    pm_second_r <= tag.k[1];
    pm_ffrac_r  <= tag.ffrac;

    s_r         <= blend_sum(pa_r, pm_r);
    s_second_r  <= pm_second_r;
    s_ffrac_r   <= pm_ffrac_r;

    if (s_vld_r && !s_second_r) begin
      s1_r <= s_r;
    end
    fm_r <= blend_prod(s1_r, s_r, s_ffrac_r);
    fa_r <= s1_r;
  end

  assign res_vld  = fm_vld_r;
  assign res_data = blend_sum(fa_r, fm_r);

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    tag.vld && tag.k[0] |-> $past(tag.vld) && ($past(tag.k) == (tag.k - 2'd1)))
    else $error("second neighbor read without its first");

  a_frame_order: assert property (@(posedge clk) disable iff (!rst_n)
    s_vld_r && s_second_r |-> $past(s_vld_r, 2) && !$past(s_second_r, 2))
    else $error("second frame result without the first");

  a_res_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> !res_vld)
    else $error("results closer than the table port allows");

endmodule

// ----- design/wbr_outq.sv -----
module wbr_outq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rsv,
  input  logic                            push,
  input  logic [wbr_pkg::SAMPLE_BITS-1:0] push_data,
  output logic                            room,
  wbr_out_if.source                       out_ch
);
  import wbr_pkg::*;

  logic [SAMPLE_BITS-1:0] mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0]       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [OQ_CW-1:0]       cnt_r, cnt_nxt, rsv_r, rsv_nxt;
  logic                   pop;

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.sample_out = mem_r[rp_r];
  assign pop               = out_ch.valid && out_ch.ready;
  // Reads in flight plus queued results never exceed the queue depth
  assign room              = (rsv_r < OQ_CW'(OQ_DEPTH));

  always_comb begin
    wp_nxt  = push ? wp_r + OQ_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + OQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + OQ_CW'(push) - OQ_CW'(pop);
    rsv_nxt = rsv_r + OQ_CW'(rsv) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      rsv_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      rsv_r <= rsv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < OQ_CW'(OQ_DEPTH)) || pop)
    else $error("result queue overflow");

  a_queued_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rsv_r)
    else $error("queued result without a reservation");

  a_rsv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rsv_r <= OQ_CW'(OQ_DEPTH))
    else $error("reservation count beyond queue depth");

endmodule

// ----- design/wavetable_bilinear_readout_core.sv -----
// Read path: the held item, the table read and its tag, the pair product, pair sum and
//   frame product registers, then the result queue feed out_ch; writes give no result.
// Throughput: one write per cycle while the result queue has room; reads are limited by the
//   single-port table RAM, as each read takes four accesses (two frames, two neighbors).
// Reset (rst_n, synchronous): clears control state and sets frames_in_use to 1;
//   table contents stay undefined until written, there is no clearing pass.
module wavetable_bilinear_readout_core #(
  parameter int unsigned TABLE_SIZE       = wbr_pkg::TABLE_SIZE_DEF,
  parameter int unsigned MAX_TABLE_FRAMES = wbr_pkg::MAX_TABLE_FRAMES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  wbr_in_if.sink                    in_ch,
  wbr_out_if.source                 out_ch,
  input  logic                      cfg_wr_en,
  input  logic [wbr_pkg::CFG_W-1:0] cfg_wr_data
);
  import wbr_pkg::*;

  localparam int unsigned IDX_W    = $clog2(TABLE_SIZE);
  localparam int unsigned RAM_DEPTH = MAX_TABLE_FRAMES << IDX_W;
  localparam int unsigned RAM_AW   = $clog2(RAM_DEPTH);

  logic                   room, rsv;
  logic                   ram_en, ram_we;
  logic [RAM_AW-1:0]      ram_addr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
  wbr_tag_t               tag;
  logic                   res_vld;
  logic [SAMPLE_BITS-1:0] res_data;

  // Item intake, config and table access sequencing
  wbr_seq #(
    .TABLE_SIZE       (TABLE_SIZE),
    .MAX_TABLE_FRAMES (MAX_TABLE_FRAMES),
    .RAM_AW           (RAM_AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .room        (room),
    .rsv         (rsv),
    .ram_en      (ram_en),
    .ram_we      (ram_we),
    .ram_addr    (ram_addr),
    .ram_wdata   (ram_wdata),
    .tag_r       (tag)
  );

  // Wavetable storage
  wbr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sample and frame blending
  wbr_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag      (tag),
    .rdata    (ram_rdata),
    .res_vld  (res_vld),
    .res_data (res_data)
  );

  // Result queue
  wbr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsv       (rsv),
    .push      (res_vld),
    .push_data (res_data),
    .room      (room),
    .out_ch    (out_ch)
  );

endmodule
